// ===== sv/sha256_fixed_8byte_digest_top_macros.svh =====
// Assertion macros for the SHA-256 fixed 8-byte digest RTL (used by shafd_outq).
`ifndef SHA256_FIXED_8BYTE_DIGEST_TOP_MACROS_SVH
`define SHA256_FIXED_8BYTE_DIGEST_TOP_MACROS_SVH

// cond must hold at every clock edge outside reset
`define SHAFD_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// ante at one edge implies cons at the next edge
`define SHAFD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/shafd_pkg.sv =====
// Package: constants, stage type and round functions for the SHA-256 8-byte digest.
package shafd_pkg;

   localparam int ROUNDS = 64;
   localparam int WIN_WORDS = 16;
   localparam int HASH_WORDS = 8;

   localparam logic [31:0] PAD_WORD = 32'h8000_0000;
   localparam logic [31:0] MSG_BITS = 32'd64;

   localparam logic [31:0] IV [HASH_WORDS] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam logic [31:0] RK [ROUNDS] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   // hv[0] is working word a, hv[7] is h; win[0] is the schedule word of this round
   typedef struct packed {
      logic [HASH_WORDS-1:0][31:0] hv;
      logic [WIN_WORDS-1:0][31:0]  win;
   } shafd_stage_type;

   function automatic logic [31:0] ssig0(input logic [31:0] v);
      return {v[6:0], v[31:7]} ^ {v[17:0], v[31:18]} ^ {3'b000, v[31:3]};
   endfunction

   function automatic logic [31:0] ssig1(input logic [31:0] v);
      return {v[16:0], v[31:17]} ^ {v[18:0], v[31:19]} ^ {10'd0, v[31:10]};
   endfunction

   function automatic logic [31:0] bsig0(input logic [31:0] v);
      return {v[1:0], v[31:2]} ^ {v[12:0], v[31:13]} ^ {v[21:0], v[31:22]};
   endfunction

   function automatic logic [31:0] bsig1(input logic [31:0] v);
      return {v[5:0], v[31:6]} ^ {v[10:0], v[31:11]} ^ {v[24:0], v[31:25]};
   endfunction

endpackage

// ===== sv/shafd_round.sv =====
// One registered SHA-256 compression round with its sliding schedule window.
module shafd_round (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     advance,
   input  logic [31:0]              rk,
   input  logic                     in_valid,
   input  shafd_pkg::shafd_stage_type in_stage,
   output logic                     out_valid,
   output shafd_pkg::shafd_stage_type out_stage
);
   import shafd_pkg::*;

   logic            valid_ff;
   shafd_stage_type stage_ff;
   shafd_stage_type stage_in;
   logic [31:0]     t1;
   logic [31:0]     t2;
   logic [31:0]     ch;
   logic [31:0]     maj;

   always_comb begin
      ch  = (in_stage.hv[4] & in_stage.hv[5]) ^ (~in_stage.hv[4] & in_stage.hv[6]);
      maj = (in_stage.hv[0] & in_stage.hv[1]) ^ (in_stage.hv[0] & in_stage.hv[2])
          ^ (in_stage.hv[1] & in_stage.hv[2]);
      t1  = in_stage.hv[7] + bsig1(in_stage.hv[4]) + ch + rk + in_stage.win[0];
      t2  = bsig0(in_stage.hv[0]) + maj;

      stage_in.hv[7] = in_stage.hv[6];
      stage_in.hv[6] = in_stage.hv[5];
      stage_in.hv[5] = in_stage.hv[4];
      stage_in.hv[4] = in_stage.hv[3] + t1;
      stage_in.hv[3] = in_stage.hv[2];
      stage_in.hv[2] = in_stage.hv[1];
      stage_in.hv[1] = in_stage.hv[0];
      stage_in.hv[0] = t1 + t2;

      for (int j = 0; j < WIN_WORDS - 1; j++) begin
         stage_in.win[j] = in_stage.win[j+1];
      end
      stage_in.win[WIN_WORDS-1] = ssig1(in_stage.win[14]) + in_stage.win[9]
                                + ssig0(in_stage.win[1]) + in_stage.win[0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         stage_ff <= stage_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_stage = stage_ff;

endmodule

// ===== sv/shafd_outq.sv =====
// Final hash addition and two-entry output queue feeding the result channel.
`include "sha256_fixed_8byte_digest_top_macros.svh"

module shafd_outq (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   input  shafd_pkg::shafd_stage_type in_stage,
   output logic                     full,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [63:0]              rsp_digest_part_0,
   output logic [63:0]              rsp_digest_part_1,
   output logic [63:0]              rsp_digest_part_2,
   output logic [63:0]              rsp_digest_part_3
);
   import shafd_pkg::*;

   logic [1:0]       count_ff;
   logic [1:0]       count_in;
   logic             full_ff;
   logic [255:0]     entry0_ff;
   logic [255:0]     entry0_in;
   logic [255:0]     entry1_ff;
   logic [255:0]     entry1_in;
   logic [255:0]     digest;
   logic             push;
   logic             pop;

   always_comb begin
      for (int j = 0; j < HASH_WORDS; j++) begin
         digest[255-32*j -: 32] = in_stage.hv[j] + IV[j];
      end
   end

   assign push = in_valid && !full_ff;
   assign pop  = rsp_valid && !rsp_stall;

   always_comb begin
      count_in  = count_ff;
      entry0_in = entry0_ff;
      entry1_in = entry1_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
         if (count_ff == 2'd0) begin
            entry0_in = digest;
         end else begin
            entry1_in = digest;
         end
      end else if (pop && !push) begin
         count_in  = count_ff - 2'd1;
         entry0_in = entry1_ff;
      end else if (push && pop) begin
         entry0_in = digest;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
         full_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         full_ff  <= (count_in == 2'd2);
      end
   end

   always_ff @(posedge clock) begin
      entry0_ff <= entry0_in;
      entry1_ff <= entry1_in;
   end

   assign full              = full_ff;
   assign rsp_valid         = (count_ff != 2'd0);
   assign rsp_digest_part_0 = entry0_ff[255:192];
   assign rsp_digest_part_1 = entry0_ff[191:128];
   assign rsp_digest_part_2 = entry0_ff[127:64];
   assign rsp_digest_part_3 = entry0_ff[63:0];

   `SHAFD_ASSERT_ALWAYS(a_count_range, count_ff != 2'd3, "output queue overfilled")
   `SHAFD_ASSERT_ALWAYS(a_full_match, full_ff == (count_ff == 2'd2), "full flag out of step")
   `SHAFD_ASSERT_NEXT(a_fill_second, push && !pop && count_ff == 2'd1, count_ff == 2'd2,
      "second entry not taken")
   `SHAFD_ASSERT_NEXT(a_drain, pop && !push && count_ff == 2'd2, count_ff == 2'd1,
      "drain lost an entry")

endmodule

// ===== sv/sha256_fixed_8byte_digest_top.sv =====
// Top level: SHA-256 of one 8-byte message, 64-stage round pipeline plus output queue.
//
//   channel | direction | handshake            | payload
//   req     | in        | req_valid/req_stall  | req_key (64b)
//   rsp     | out       | rsp_valid/rsp_stall  | rsp_digest_part_0..3 (64b each)
//
// One transaction per cycle sustained while the output queue has room; each passes 64 rounds, then the queue.
// The round pipeline moves as one when the two-entry output queue has room.
// req_stall is the registered queue-full flag, so a full queue freezes every stage.
// Reset clears valid bits, the queue count and the queue-full flag only.
module sha256_fixed_8byte_digest_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [63:0] req_key,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_digest_part_0,
   output logic [63:0] rsp_digest_part_1,
   output logic [63:0] rsp_digest_part_2,
   output logic [63:0] rsp_digest_part_3
);
   import shafd_pkg::*;

   shafd_stage_type    stage_bus [ROUNDS+1];
   shafd_stage_type    key_stage;
   logic [ROUNDS:0]    valid_bus;
   logic               full;
   logic               advance;

   assign advance = !full;
   assign req_stall = full;
   assign valid_bus[0] = req_valid;
   assign stage_bus[0] = key_stage;

   always_comb begin
      for (int j = 0; j < HASH_WORDS; j++) begin
         key_stage.hv[j] = IV[j];
      end
      for (int j = 0; j < WIN_WORDS; j++) begin
         key_stage.win[j] = 32'd0;
      end
      key_stage.win[0]  = req_key[63:32];
      key_stage.win[1]  = req_key[31:0];
      key_stage.win[2]  = PAD_WORD;
      key_stage.win[15] = MSG_BITS;
   end

   for (genvar r = 0; r < ROUNDS; r++) begin : g_round
      shafd_round u_round (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .rk        (RK[r]),
         .in_valid  (valid_bus[r]),
         .in_stage  (stage_bus[r]),
         .out_valid (valid_bus[r+1]),
         .out_stage (stage_bus[r+1])
      );
   end

   shafd_outq u_outq (
      .clock             (clock),
      .reset             (reset),
      .in_valid          (valid_bus[ROUNDS]),
      .in_stage          (stage_bus[ROUNDS]),
      .full              (full),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_digest_part_0 (rsp_digest_part_0),
      .rsp_digest_part_1 (rsp_digest_part_1),
      .rsp_digest_part_2 (rsp_digest_part_2),
      .rsp_digest_part_3 (rsp_digest_part_3)
   );

endmodule
